@@ rtl/pmt_section_parser_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the program map section parser
// Shared property templates; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef PMT_SECTION_PARSER_UNIT_MACROS_SVH
`define PMT_SECTION_PARSER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PMT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pmt_sp_pkg.sv @@
// ----------------------------------------------------------------------------
// pmt_sp_pkg
// Types and record kind codes shared by the section parser modules.
// ----------------------------------------------------------------------------
package pmt_sp_pkg;

  // Record kinds carried on the output tuser.
  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_STREAM = 3'd1;
  localparam logic [2:0] KIND_DESC   = 3'd2;
  localparam logic [2:0] KIND_CRC    = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  // Reset value of the target packet id register.
  localparam logic [12:0] TARGET_PID_RESET = 13'h1000;

  // One input byte with its tags.
  typedef struct packed {
    logic [12:0] packet_id;
    logic [7:0]  data_byte;
    logic        section_start;
  } pmt_sp_item_t;

  // One output record.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  field_a;
    logic [15:0] field_b;
    logic [11:0] field_c;
    logic        syntax_flag;
    logic [4:0]  table_version;
    logic        current_next;
    logic [7:0]  section_index;
    logic [7:0]  last_section_index;
    logic [12:0] clock_ref_pid;
    logic [9:0]  info_length;
    logic [31:0] crc_word;
  } pmt_sp_result_t;

endpackage

@@ rtl/pmt_sp_in_stage.sv @@
// ----------------------------------------------------------------------------
// pmt_sp_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module pmt_sp_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  pmt_sp_pkg::pmt_sp_item_t s_item,
  input  logic                  fire,
  output logic                  item_valid,
  output pmt_sp_pkg::pmt_sp_item_t item
);
  import pmt_sp_pkg::*;

  // A new beat is taken whenever the register is empty or drains this cycle.
  assign s_tready = !item_valid || fire;

  // Valid flag of the held byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule

@@ rtl/pmt_sp_parser.sv @@
// ----------------------------------------------------------------------------
// pmt_sp_parser
// Section parse state and the per-byte decode that forms one output record.
// ----------------------------------------------------------------------------
module pmt_sp_parser #(
  parameter int MAX_STREAMS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  pmt_sp_pkg::pmt_sp_item_t item,
  input  logic [12:0]             target_pid,
  input  logic                    fire,
  output logic                    emit,
  output pmt_sp_pkg::pmt_sp_result_t result
);
  import pmt_sp_pkg::*;

  // Parse phases.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HEAD  = 3'd1;
  localparam logic [2:0] PH_SKIP  = 3'd2;
  localparam logic [2:0] PH_ENTRY = 3'd3;
  localparam logic [2:0] PH_DESC  = 3'd4;
  localparam logic [2:0] PH_CRC   = 3'd5;

  localparam logic [7:0] STREAM_LIMIT = 8'(MAX_STREAMS);

  // Parse state.
  logic [2:0]  phase, phase_next;
  logic [11:0] offset, offset_next;
  logic [11:0] held_len, held_len_next;
  logic [9:0]  skip_cnt, skip_cnt_next;
  logic [2:0]  entry_off, entry_off_next;
  logic [7:0]  stream_count, stream_count_next;
  logic [31:0] crc_shift, crc_shift_next;

  // Captured header fields.
  logic [7:0]  table_code, table_code_next;
  logic        syntax, syntax_next;
  logic [15:0] prog_num, prog_num_next;
  logic [4:0]  version, version_next;
  logic        cur_next, cur_next_next;
  logic [7:0]  sec_idx, sec_idx_next;
  logic [7:0]  last_idx, last_idx_next;
  logic [12:0] pcr_pid, pcr_pid_next;

  // Entry head bytes.
  logic [7:0]  ent_type, ent_type_next;
  logic [4:0]  ent_pid_hi, ent_pid_hi_next;
  logic [7:0]  ent_pid_lo, ent_pid_lo_next;
  logic [1:0]  ent_info_hi, ent_info_hi_next;

  logic        match;
  logic        res_flag;
  logic [7:0]  b;
  logic [9:0]  skip_full;
  logic [9:0]  skip_dec;
  logic [9:0]  ent_info;
  logic        at_crc_pos;
  logic [13:0] head_end;
  logic [13:0] desc_end;
  logic        err;

  assign match = item_valid && (item.packet_id == target_pid);
  assign emit  = match && res_flag;
  assign b     = item.data_byte;

  // Helper terms of the current byte.
  assign skip_full  = {skip_cnt[9:8], b};
  assign skip_dec   = skip_cnt - 10'd1;
  assign ent_info   = {ent_info_hi, b};
  // The next block starts on the CRC when offset + 1 equals length - 1.
  assign at_crc_pos = ({1'b0, offset} + 13'd2) == {1'b0, held_len};
  assign head_end   = {2'b00, offset} + 14'd5;
  assign desc_end   = {2'b00, offset} + 14'd1 + {4'b0000, ent_info};

  // Per-byte decode.
  always_comb begin
    phase_next        = phase;
    offset_next       = offset;
    held_len_next     = held_len;
    skip_cnt_next     = skip_cnt;
    entry_off_next    = entry_off;
    stream_count_next = stream_count;
    crc_shift_next    = crc_shift;
    table_code_next   = table_code;
    syntax_next       = syntax;
    prog_num_next     = prog_num;
    version_next      = version;
    cur_next_next     = cur_next;
    sec_idx_next      = sec_idx;
    last_idx_next     = last_idx;
    pcr_pid_next      = pcr_pid;
    ent_type_next     = ent_type;
    ent_pid_hi_next   = ent_pid_hi;
    ent_pid_lo_next   = ent_pid_lo;
    ent_info_hi_next  = ent_info_hi;
    result            = '0;
    res_flag          = 1'b0;
    err               = 1'b0;

    if (item.section_start) begin
      // A section start on the target packet id always restarts parsing at the table id.
      table_code_next   = b;
      held_len_next     = '0;
      skip_cnt_next     = '0;
      entry_off_next    = '0;
      stream_count_next = '0;
      crc_shift_next    = '0;
      offset_next       = 12'd1;
      phase_next        = PH_HEAD;
    end else begin
      // The byte offset advances and saturates, except while idle or reading the CRC.
      if (phase != PH_CRC && phase != PH_IDLE && offset != 12'hFFF) begin
        offset_next = offset + 12'd1;
      end

      unique case (phase)
        PH_IDLE: begin
        end

        PH_HEAD: begin
          case (offset)
            12'd1: begin
              syntax_next   = b[7];
              held_len_next = {b[3:0], 8'h00};
            end
            12'd2: held_len_next = {held_len[11:8], b};
            12'd3: prog_num_next[15:8] = b;
            12'd4: prog_num_next[7:0] = b;
            12'd5: begin
              version_next  = b[5:1];
              cur_next_next = b[0];
            end
            12'd6: sec_idx_next = b;
            12'd7: last_idx_next = b;
            12'd8: pcr_pid_next[12:8] = b[4:0];
            12'd9: pcr_pid_next[7:0] = b;
            12'd10: skip_cnt_next = {b[1:0], 8'h00};
            default: begin
              // Last header byte: check the length, then emit the header or an error.
              skip_cnt_next = skip_full;
              if ({1'b0, held_len} < (13'd13 + {3'b000, skip_full})) begin
                err = 1'b1;
              end else begin
                res_flag                  = 1'b1;
                result.kind               = KIND_HEADER;
                result.field_a            = table_code;
                result.field_b            = prog_num;
                result.field_c            = held_len;
                result.syntax_flag        = syntax;
                result.table_version      = version;
                result.current_next       = cur_next;
                result.section_index      = sec_idx;
                result.last_section_index = last_idx;
                result.clock_ref_pid      = pcr_pid;
                result.info_length        = skip_full;
                if (skip_full != 10'd0) begin
                  phase_next = PH_SKIP;
                end else begin
                  entry_off_next = '0;
                  phase_next     = at_crc_pos ? PH_CRC : PH_ENTRY;
                end
              end
            end
          endcase
        end

        PH_SKIP: begin
          skip_cnt_next = skip_dec;
          if (skip_dec == 10'd0) begin
            entry_off_next = '0;
            crc_shift_next = '0;
            phase_next     = at_crc_pos ? PH_CRC : PH_ENTRY;
          end
        end

        PH_ENTRY: begin
          if (entry_off == 3'd0 &&
              (stream_count >= STREAM_LIMIT ||
               (held_len != 12'd0 && head_end >= {2'b00, held_len}))) begin
            // Too many streams or the entry head runs into the CRC.
            err = 1'b1;
          end else if (entry_off < 3'd4) begin
            case (entry_off)
              3'd0:    ent_type_next = b;
              3'd1:    ent_pid_hi_next = b[4:0];
              3'd2:    ent_pid_lo_next = b;
              default: ent_info_hi_next = b[1:0];
            endcase
            entry_off_next = entry_off + 3'd1;
          end else if (held_len != 12'd0 && desc_end >= {2'b00, held_len}) begin
            // The descriptors would run into the CRC.
            err = 1'b1;
          end else begin
            res_flag          = 1'b1;
            result.kind       = KIND_STREAM;
            result.field_a    = ent_type;
            result.field_b    = {3'b000, ent_pid_hi, ent_pid_lo};
            result.field_c    = {2'b00, ent_info};
            stream_count_next = stream_count + 8'd1;
            if (ent_info != 10'd0) begin
              skip_cnt_next = ent_info;
              phase_next    = PH_DESC;
            end else begin
              entry_off_next = '0;
              crc_shift_next = '0;
              phase_next     = at_crc_pos ? PH_CRC : PH_ENTRY;
            end
          end
        end

        PH_DESC: begin
          res_flag       = 1'b1;
          result.kind    = KIND_DESC;
          result.field_a = b;
          skip_cnt_next  = skip_dec;
          if (skip_dec == 10'd0) begin
            entry_off_next = '0;
            crc_shift_next = '0;
            phase_next     = at_crc_pos ? PH_CRC : PH_ENTRY;
          end
        end

        PH_CRC: begin
          // CRC bytes shift in most significant first.
          crc_shift_next = {crc_shift[23:0], b};
          entry_off_next = entry_off + 3'd1;
          if (entry_off == 3'd3) begin
            res_flag        = 1'b1;
            result.kind     = KIND_CRC;
            result.crc_word = {crc_shift[23:0], b};
            phase_next      = PH_IDLE;
          end
        end

        default: begin
        end
      endcase

      // Any error ends the section with a bare error record.
      if (err) begin
        res_flag    = 1'b1;
        result      = '0;
        result.kind = KIND_ERROR;
        phase_next  = PH_IDLE;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      offset       <= '0;
      held_len     <= '0;
      skip_cnt     <= '0;
      entry_off    <= '0;
      stream_count <= '0;
    end else if (fire && match) begin
      phase        <= phase_next;
      offset       <= offset_next;
      held_len     <= held_len_next;
      skip_cnt     <= skip_cnt_next;
      entry_off    <= entry_off_next;
      stream_count <= stream_count_next;
    end
  end

  // Captured header, entry and CRC bytes.
  always_ff @(posedge clk) begin
    if (fire && match) begin
      crc_shift   <= crc_shift_next;
      table_code  <= table_code_next;
      syntax      <= syntax_next;
      prog_num    <= prog_num_next;
      version     <= version_next;
      cur_next    <= cur_next_next;
      sec_idx     <= sec_idx_next;
      last_idx    <= last_idx_next;
      pcr_pid     <= pcr_pid_next;
      ent_type    <= ent_type_next;
      ent_pid_hi  <= ent_pid_hi_next;
      ent_pid_lo  <= ent_pid_lo_next;
      ent_info_hi <= ent_info_hi_next;
    end
  end

endmodule

@@ rtl/pmt_sp_out_stage.sv @@
// ----------------------------------------------------------------------------
// pmt_sp_out_stage
// Result register that holds one record until the downstream takes it.
// ----------------------------------------------------------------------------
module pmt_sp_out_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  pmt_sp_pkg::pmt_sp_result_t result,
  output logic                      can_load,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [119:0]              m_tdata,
  output logic [2:0]                m_tuser
);
  import pmt_sp_pkg::*;

  pmt_sp_result_t held;

  // Room for a record when empty or when the held one leaves this cycle.
  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= result;
    end
  end

  // Pack the record fields, lowest field in the lowest bits.
  assign m_tdata = {6'b000000, held.crc_word, held.info_length, held.clock_ref_pid,
                    held.last_section_index, held.section_index, held.current_next,
                    held.table_version, held.syntax_flag, held.field_c,
                    held.field_b, held.field_a};
  assign m_tuser = held.kind;

endmodule

@@ rtl/pmt_section_parser_unit.sv @@
// An accepted byte is held in the input register; its record is presented from the result register.
// Throughput: one byte per cycle; the input register and the result register each
// move one beat a cycle, and only a held record with tready low stalls the input.
// Reset (rst, synchronous, active high) empties both registers, returns the parser
// to idle waiting for a section start and sets target_pid to 4096.
// ----------------------------------------------------------------------------
// pmt_section_parser_unit
// Program map section parser: turns tagged payload bytes into header, stream,
// descriptor, CRC and error records.
// ----------------------------------------------------------------------------
module pmt_section_parser_unit #(
  parameter int MAX_STREAMS = 16
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration write channel: target_pid.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [12:0]  cfg_data,
  // Input stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic [13:0]  s_tuser,   // [12:0] packet_id, [13] section_start
  // Output stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] field_a, [23:8] field_b, [35:24] field_c, [36] syntax_flag,
  // [41:37] table_version, [42] current_next, [50:43] section_index,
  // [58:51] last_section_index, [71:59] clock_ref_pid, [81:72] info_length,
  // [113:82] crc_word, [119:114] zero
  output logic [119:0] m_tdata,
  output logic [2:0]   m_tuser    // [2:0] kind
);
  import pmt_sp_pkg::*;
  `include "pmt_section_parser_unit_macros.svh"

  logic [12:0]    target_pid;
  pmt_sp_item_t   s_item;
  pmt_sp_item_t   item;
  logic           item_valid;
  logic           fire;
  logic           emit;
  logic           can_load;
  pmt_sp_result_t result;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_pid <= TARGET_PID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      target_pid <= cfg_data;
    end
  end

  // Unpack the input beat.
  assign s_item.packet_id     = s_tuser[12:0];
  assign s_item.section_start = s_tuser[13];
  assign s_item.data_byte     = s_tdata;

  // The held byte is consumed unless its record finds the output full.
  assign fire = item_valid && (!emit || can_load);

  pmt_sp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_item     (s_item),
    .fire       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  pmt_sp_parser #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .target_pid (target_pid),
    .fire       (fire),
    .emit       (emit),
    .result     (result)
  );

  pmt_sp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && emit),
    .result   (result),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Checks.
  `PMT_ASSERT_IMP(a_error_bare, m_tvalid && m_tuser == KIND_ERROR, m_tdata == '0, "error record carries data")
  `PMT_ASSERT_IMP(a_crc_only, m_tvalid && m_tuser == KIND_CRC, m_tdata[81:0] == '0, "crc record carries other fields")
  `PMT_ASSERT_IMP(a_ready_free, !m_tvalid || m_tready, s_tready, "input stalled with free output")
  `PMT_ASSERT_NXT(a_emit_shows, fire && emit, m_tvalid, "emitted record not presented")

endmodule

@@ test/pmt_record_check.sv @@
// ----------------------------------------------------------------------------
// pmt_record_check
// Watches the configuration, byte and record channels of the section parser.
// Every accepted byte runs through a local copy of the parser state, and the
// records it produces wait in order until the block delivers its own. Each
// delivered record is compared field by field with the oldest waiting one.
// ----------------------------------------------------------------------------
module pmt_record_check #(
  parameter int MAX_STREAMS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [12:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic [13:0]  s_tuser,   // [12:0] packet_id, [13] section_start
  input  logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] field_a, [23:8] field_b, [35:24] field_c, [36] syntax_flag,
  // [41:37] table_version, [42] current_next, [50:43] section_index,
  // [58:51] last_section_index, [71:59] clock_ref_pid, [81:72] info_length,
  // [113:82] crc_word, [119:114] zero
  input  logic [119:0] m_tdata,
  input  logic [2:0]   m_tuser,   // [2:0] kind
  output int           outstanding,
  output int           mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  import pmt_sp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEADER,
    ST_SKIP,
    ST_ENTRY,
    ST_DESC,
    ST_CRC
  } parse_phase_e;

  // Parser state as the block should hold it.
  logic [12:0]    target_pid;
  parse_phase_e   phase;
  logic [11:0]    sec_off;
  logic [11:0]    sec_len;
  logic [7:0]     table_code;
  logic           syntax_bit;
  logic [15:0]    prog_num;
  logic [4:0]     version;
  logic           cur_next;
  logic [7:0]     sect_idx;
  logic [7:0]     last_idx;
  logic [12:0]    pcr_pid;
  logic [9:0]     remaining;
  logic [2:0]     head_idx;
  logic [31:0]    head_bytes;
  logic [7:0]     stream_cnt;
  logic [31:0]    crc_acc;

  // Records predicted but not yet delivered, oldest first.
  pmt_sp_result_t due_records[$];

  task automatic clear_header();
    syntax_bit = 1'b0;
    prog_num   = '0;
    version    = '0;
    cur_next   = 1'b0;
    sect_idx   = '0;
    last_idx   = '0;
    pcr_pid    = '0;
  endtask

  task automatic clear_parser();
    target_pid = TARGET_PID_RESET;
    phase      = ST_IDLE;
    sec_off    = '0;
    sec_len    = '0;
    table_code = '0;
    remaining  = '0;
    head_idx   = '0;
    head_bytes = '0;
    stream_cnt = '0;
    crc_acc    = '0;
    clear_header();
  endtask

  // The next block at offset pos is either a stream entry or the CRC word.
  task automatic enter_block(input int pos);
    head_idx   = '0;
    head_bytes = '0;
    crc_acc    = '0;
    phase      = (pos == int'(sec_len) - 1) ? ST_CRC : ST_ENTRY;
  endtask

  task automatic raise_error(output bit emitted, output pmt_sp_result_t rec);
    rec      = '0;
    rec.kind = KIND_ERROR;
    emitted  = 1'b1;
    phase    = ST_IDLE;
  endtask

  // Advances the parser by one byte and returns the record it causes, if any.
  task automatic parse_byte(input logic [12:0] pid, input logic [7:0] b, input logic st,
                            output bit emitted, output pmt_sp_result_t rec);
    int         cur;
    int         crc_at;
    logic [9:0] es_len;
    cur     = int'(sec_off);
    emitted = 1'b0;
    rec     = '0;
    if (pid != target_pid) return;

    // A section start restarts parsing at this byte, whatever came before.
    if (st) begin
      table_code = b;
      clear_header();
      sec_len    = '0;
      remaining  = '0;
      head_idx   = '0;
      head_bytes = '0;
      stream_cnt = '0;
      crc_acc    = '0;
      sec_off    = 12'd1;
      phase      = ST_HEADER;
      return;
    end
    if (phase == ST_IDLE) return;

    if (phase != ST_CRC && sec_off < 12'd4095) sec_off = 12'(cur + 1);
    crc_at = int'(sec_len) - 1;

    case (phase)
      ST_HEADER: begin
        case (cur)
          1: begin
            syntax_bit = b[7];
            sec_len    = {b[3:0], 8'h00};
          end
          2: sec_len[7:0] = b;
          3: prog_num[15:8] = b;
          4: prog_num[7:0] = b;
          5: begin
            version  = b[5:1];
            cur_next = b[0];
          end
          6: sect_idx = b;
          7: last_idx = b;
          8: pcr_pid[12:8] = b[4:0];
          9: pcr_pid[7:0] = b;
          10: remaining = {b[1:0], 8'h00};
          default: begin
            remaining[7:0] = b;
            // The length must cover the fixed fields, the program info and the CRC.
            if (int'(sec_len) < 13 + int'(remaining)) begin
              raise_error(emitted, rec);
            end else begin
              emitted                = 1'b1;
              rec.kind               = KIND_HEADER;
              rec.field_a            = table_code;
              rec.field_b            = prog_num;
              rec.field_c            = sec_len;
              rec.syntax_flag        = syntax_bit;
              rec.table_version      = version;
              rec.current_next       = cur_next;
              rec.section_index      = sect_idx;
              rec.last_section_index = last_idx;
              rec.clock_ref_pid      = pcr_pid;
              rec.info_length        = remaining;
              if (remaining != 0) phase = ST_SKIP;
              else enter_block(cur + 1);
            end
          end
        endcase
      end

      ST_SKIP: begin
        remaining = remaining - 10'd1;
        if (remaining == 0) enter_block(cur + 1);
      end

      ST_ENTRY: begin
        if (head_idx == 0 && (int'(stream_cnt) >= MAX_STREAMS || cur + 5 > crc_at)) begin
          raise_error(emitted, rec);
        end else if (head_idx < 4) begin
          head_bytes = {head_bytes[23:0], b};
          head_idx   = head_idx + 3'd1;
        end else begin
          es_len = {head_bytes[1:0], b};
          // Descriptors that would run into the CRC word spoil the entry.
          if (cur + 1 + int'(es_len) > crc_at) begin
            raise_error(emitted, rec);
          end else begin
            emitted     = 1'b1;
            rec.kind    = KIND_STREAM;
            rec.field_a = head_bytes[31:24];
            rec.field_b = {3'b000, head_bytes[20:16], head_bytes[15:8]};
            rec.field_c = {2'b00, es_len};
            stream_cnt  = stream_cnt + 8'd1;
            if (es_len != 0) begin
              remaining = es_len;
              phase     = ST_DESC;
            end else begin
              enter_block(cur + 1);
            end
          end
        end
      end

      ST_DESC: begin
        emitted     = 1'b1;
        rec.kind    = KIND_DESC;
        rec.field_a = b;
        remaining   = remaining - 10'd1;
        if (remaining == 0) enter_block(cur + 1);
      end

      ST_CRC: begin
        crc_acc  = {crc_acc[23:0], b};
        head_idx = head_idx + 3'd1;
        if (head_idx == 4) begin
          emitted      = 1'b1;
          rec.kind     = KIND_CRC;
          rec.crc_word = crc_acc;
          phase        = ST_IDLE;
        end
      end

      default: ;
    endcase
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic compare_record(input pmt_sp_result_t want, input pmt_sp_result_t got);
    check_field("kind", want.kind, got.kind);
    check_field("field_a", want.field_a, got.field_a);
    check_field("field_b", want.field_b, got.field_b);
    check_field("field_c", want.field_c, got.field_c);
    check_field("syntax_flag", want.syntax_flag, got.syntax_flag);
    check_field("table_version", want.table_version, got.table_version);
    check_field("current_next", want.current_next, got.current_next);
    check_field("section_index", want.section_index, got.section_index);
    check_field("last_section_index", want.last_section_index, got.last_section_index);
    check_field("clock_ref_pid", want.clock_ref_pid, got.clock_ref_pid);
    check_field("info_length", want.info_length, got.info_length);
    check_field("crc_word", want.crc_word, got.crc_word);
  endtask

  // All three channels are sampled at the clock edge where their beats complete.
  always @(posedge clk) begin
    bit             emitted;
    pmt_sp_result_t rec;
    pmt_sp_result_t got;
    if (rst) begin
      clear_parser();
      due_records.delete();
    end else begin
      if (cfg_valid && cfg_ready) target_pid = cfg_data;

      if (m_tvalid && m_tready) begin
        got.kind               = m_tuser;
        got.field_a            = m_tdata[7:0];
        got.field_b            = m_tdata[23:8];
        got.field_c            = m_tdata[35:24];
        got.syntax_flag        = m_tdata[36];
        got.table_version      = m_tdata[41:37];
        got.current_next       = m_tdata[42];
        got.section_index      = m_tdata[50:43];
        got.last_section_index = m_tdata[58:51];
        got.clock_ref_pid      = m_tdata[71:59];
        got.info_length        = m_tdata[81:72];
        got.crc_word           = m_tdata[113:82];
        if (due_records.size() == 0) begin
          $error("record of kind %0d delivered with none predicted", got.kind);
          mismatches++;
        end else begin
          compare_record(due_records.pop_front(), got);
        end
      end

      if (s_tvalid && s_tready) begin
        parse_byte(s_tuser[12:0], s_tdata, s_tuser[13], emitted, rec);
        if (emitted) due_records.push_back(rec);
      end
    end
    outstanding <= due_records.size();
  end

endmodule

@@ test/pmt_section_parser_unit_tb.sv @@
// ----------------------------------------------------------------------------
// pmt_section_parser_unit_tb
// Feeds the section parser with program map sections built byte by byte on a
// chosen packet id, mixed with bytes of other ids, stray bytes, cut sections
// and sections with wrong lengths or too many streams. Both stream sides idle
// at random; a separate checker predicts and compares every record.
// ----------------------------------------------------------------------------
module pmt_section_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmt_sp_pkg::*;

  localparam int MAX_STREAMS    = 16;
  localparam int PHASE_BYTES    = 20;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 120;

  // How the free bits of a section are filled.
  localparam int FILL_RAND  = 0;
  localparam int FILL_ONES  = 1;
  localparam int FILL_ZEROS = 2;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [12:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;   // [7:0] data_byte
  logic [13:0]  s_tuser;   // [12:0] packet_id, [13] section_start
  logic         m_tvalid;
  logic         m_tready;
  // [7:0] field_a, [23:8] field_b, [35:24] field_c, [36] syntax_flag,
  // [41:37] table_version, [42] current_next, [50:43] section_index,
  // [58:51] last_section_index, [71:59] clock_ref_pid, [81:72] info_length,
  // [113:82] crc_word, [119:114] zero
  logic [119:0] m_tdata;
  logic [2:0]   m_tuser;   // [2:0] kind

  int outstanding;
  int mismatches;

  // Stimulus controls shared between the sender and the receiver.
  logic [12:0] target;
  int          items_sent;
  bit          idle_en;
  bit          stall_en;
  bit          noise_en;
  bit          hold_req;

  pmt_section_parser_unit #(
    .MAX_STREAMS(MAX_STREAMS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  pmt_record_check #(
    .MAX_STREAMS(MAX_STREAMS)
  ) records_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .outstanding(outstanding),
    .mismatches (mismatches)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: a random wait before each beat, and one long hold on request.
  initial begin : record_sink
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        gap      = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        gap = stall_en ? $urandom_range(0, 3) : 0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Watchdog: ends the run when no beat moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("pmt_section_parser_unit: mismatch");
    $finish;
  end

  function automatic logic [7:0] fill_byte(input int fill);
    case (fill)
      FILL_ONES:  return 8'hFF;
      FILL_ZEROS: return 8'h00;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [12:0] foreign_pid();
    logic [12:0] pid;
    do pid = 13'($urandom_range(0, 8191)); while (pid == target);
    return pid;
  endfunction

  // Offers one beat, after a random gap when idle_en is set, and returns once it is taken.
  task automatic send_beat(input logic [12:0] pid, input logic [7:0] b, input logic st);
    int gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= {st, pid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (pid == target) items_sent++;
  endtask

  task automatic write_target(input logic [12:0] pid);
    cfg_valid <= 1'b1;
    cfg_data  <= pid;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    target = pid;
  endtask

  // Stops sending until every predicted record has come out and the pipe is empty.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Builds one section and sends it; len_delta bends the length field and a
  // nonzero cut_at abandons the section after that many bytes.
  task automatic send_section(input int n_streams, input int info_len, input int desc_lo,
                              input int desc_hi, input int len_delta, input int cut_at,
                              input int fill);
    logic [7:0]  sect_q[$];
    logic [7:0]  ent_q[$];
    logic [7:0]  r;
    logic [9:0]  es;
    logic [9:0]  info10;
    logic [11:0] len12;
    int          len;
    info10 = 10'(info_len);

    // Stream entries: type, pid, info length and descriptor bytes.
    for (int k = 0; k < n_streams; k++) begin
      es = 10'($urandom_range(desc_lo, desc_hi));
      ent_q.push_back(fill_byte(fill));
      ent_q.push_back(fill_byte(fill));
      ent_q.push_back(fill_byte(fill));
      r = fill_byte(fill);
      ent_q.push_back({r[7:2], es[9:8]});
      ent_q.push_back(es[7:0]);
      repeat (es) ent_q.push_back(fill_byte(fill));
    end

    len = 13 + info_len + ent_q.size() + len_delta;
    if (len < 0) len = 0;
    if (len > 4095) len = 4095;
    len12 = 12'(len);

    // Fixed header: table id through program info length.
    sect_q.push_back(fill_byte(fill));
    r = fill_byte(fill);
    sect_q.push_back({r[7:4], len12[11:8]});
    sect_q.push_back(len12[7:0]);
    repeat (7) sect_q.push_back(fill_byte(fill));
    r = fill_byte(fill);
    sect_q.push_back({r[7:2], info10[9:8]});
    sect_q.push_back(info10[7:0]);
    repeat (info_len) sect_q.push_back(fill_byte(fill));
    foreach (ent_q[k]) sect_q.push_back(ent_q[k]);
    repeat (4) sect_q.push_back(fill_byte(fill));

    foreach (sect_q[i]) begin
      if (cut_at > 0 && i >= cut_at) break;
      if (noise_en && $urandom_range(0, 9) == 0) begin
        send_beat(foreign_pid(), fill_byte(FILL_RAND), 1'($urandom_range(0, 1)));
      end
      send_beat(target, sect_q[i], i == 0);
    end
  endtask

  // One section of random shape; most are well formed.
  task automatic random_section();
    int pick;
    int n;
    int info;
    int hi;
    int delta;
    int cut;
    pick     = $urandom_range(0, 19);
    n        = $urandom_range(0, 4);
    info     = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
    hi       = $urandom_range(0, 6);
    delta    = 0;
    cut      = 0;
    idle_en  = ($urandom_range(0, 3) != 0);
    stall_en = ($urandom_range(0, 3) != 0);
    noise_en = ($urandom_range(0, 2) == 0);
    case (pick)
      0, 1: delta = int'($urandom_range(0, 12)) - 6;
      2: delta = $urandom_range(0, 4095);
      3: cut = $urandom_range(1, 24);
      4: n = $urandom_range(MAX_STREAMS - 1, MAX_STREAMS + 2);
      5: begin
        // Stray bytes without a section start.
        repeat ($urandom_range(1, 3)) send_beat(target, fill_byte(FILL_RAND), 1'b0);
      end
      default: ;
    endcase
    send_section(n, info, 0, hi, delta, cut, FILL_RAND);
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    logic [12:0] phase_pids[6];
    int          phase_end;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    target     = TARGET_PID_RESET;
    items_sent = 0;
    idle_en    = 1'b1;
    stall_en   = 1'b1;
    noise_en   = 1'b0;
    hold_req   = 1'b0;
    phase_pids[0] = 13'h0000;
    phase_pids[1] = 13'h1FFF;
    phase_pids[2] = 13'($urandom_range(0, 8191));
    phase_pids[3] = 13'($urandom_range(0, 8191));
    phase_pids[4] = TARGET_PID_RESET;
    phase_pids[5] = 13'($urandom_range(0, 8191));
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sections on the reset packet id, before any register write.
    send_beat(foreign_pid(), 8'h02, 1'b1);
    send_beat(target, 8'h5A, 1'b0);
    send_section(1, 0, 3, 3, 0, 0, FILL_ONES);
    send_section(0, 0, 0, 0, 0, 0, FILL_ZEROS);
    noise_en = 1'b1;
    send_section(2, 3, 1, 2, 0, 0, FILL_RAND);
    // Length too short for the program info.
    send_section(0, 5, 0, 0, -1, 0, FILL_RAND);
    // Entry head runs into the CRC word.
    send_section(1, 0, 0, 0, -3, 0, FILL_RAND);
    // Entry descriptors run into the CRC word.
    send_section(1, 0, 4, 4, -2, 0, FILL_RAND);
    // New section start in the middle of a section.
    send_section(2, 0, 2, 2, 0, 7, FILL_RAND);
    send_section(1, 0, 1, 1, 0, 0, FILL_RAND);
    // One stream more than the limit.
    send_section(MAX_STREAMS + 1, 0, 0, 0, 0, 0, FILL_RAND);

    // Receiver holds off while a long descriptor run keeps the sender busy.
    hold_req = 1'b1;
    send_section(1, 0, 60, 60, 0, 0, FILL_RAND);

    // Random sections under several packet ids.
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_target(phase_pids[p]);
      phase_end = items_sent + PHASE_BYTES;
      // Largest program info once, with a small stream list after it.
      if (p == 2) send_section(1, 1023, 0, 6, 0, 0, FILL_RAND);
      while (items_sent < phase_end) random_section();
    end

    wait_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("pmt_section_parser_unit: match");
    end else begin
      $display("pmt_section_parser_unit: mismatch");
    end
    $finish;
  end

endmodule
